[rtl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int NUM_FIELDS_CH    = 4;
  localparam int ROOT_BITS        = 3;   // 8 result bits, one per root step

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;
  localparam logic [1:0] REG_SENS     = 2'd3;

  typedef struct packed {
    logic [7:0] pix_ch0;
    logic [7:0] pix_ch1;
    logic [7:0] pix_ch2;
    logic [7:0] pix_ch3;
  } sem_in_t;

  typedef struct packed {
    logic [10:0] out_col;
    logic [15:0] out_row;
    logic [7:0]  res_ch0;
    logic [7:0]  res_ch1;
    logic [7:0]  res_ch2;
    logic [7:0]  res_ch3;
    logic        run_last;
  } sem_out_t;

  // Step controls from the sequencer to every lane
  typedef struct packed {
    logic                 grad;
    logic                 square;
    logic                 scale;
    logic                 root;
    logic [ROOT_BITS-1:0] bit_idx;
  } sem_lane_ctl_t;

endpackage

[rtl/sem_ram.sv]
// ----------------------------------------------------------------------------
// sem_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sem_lane.sv]
// ----------------------------------------------------------------------------
// sem_lane
// One channel lane: Sobel gradients, squares, gain and a bit-serial root.
// ----------------------------------------------------------------------------
module sem_lane
  import sem_pkg::*;
(
  input  logic                clk,
  input  sem_lane_ctl_t       ctl,
  input  logic [2:0]          sens,
  input  logic [8:0][7:0]     tap,
  output logic [7:0]          mag
);

  logic [9:0]  ax, ay;
  logic [19:0] sqx, sqy;
  logic [26:0] val;
  logic [7:0]  res;

  logic [9:0]  sum_xp, sum_xn, sum_yp, sum_yn;
  logic [10:0] gx, gy;
  logic [20:0] sq_sum;
  logic [5:0]  s2;
  logic [7:0]  trial;
  logic [15:0] trial_sq;

  // Gradients from the window taps, square sum, gain and root trial
  always_comb begin
    sum_xp = 10'(tap[2]) + {1'b0, tap[5], 1'b0} + 10'(tap[8]);
    sum_xn = 10'(tap[0]) + {1'b0, tap[3], 1'b0} + 10'(tap[6]);
    sum_yp = 10'(tap[6]) + {1'b0, tap[7], 1'b0} + 10'(tap[8]);
    sum_yn = 10'(tap[0]) + {1'b0, tap[1], 1'b0} + 10'(tap[2]);
    gx     = {1'b0, sum_xp} - {1'b0, sum_xn};
    gy     = {1'b0, sum_yp} - {1'b0, sum_yn};
    sq_sum = {1'b0, sqx} + {1'b0, sqy};
    s2     = {3'b0, sens} * {3'b0, sens};
    trial  = res | (8'd1 << ctl.bit_idx);
    trial_sq = {8'b0, trial} * {8'b0, trial};
  end

  // Advance the lane one step at a time
  always_ff @(posedge clk) begin
    if (ctl.grad) begin
      ax <= gx[10] ? 10'(-gx) : gx[9:0];
      ay <= gy[10] ? 10'(-gy) : gy[9:0];
    end
    if (ctl.square) begin
      sqx <= {10'b0, ax} * {10'b0, ax};
      sqy <= {10'b0, ay} * {10'b0, ay};
    end
    if (ctl.scale) begin
      val <= {6'b0, sq_sum} * {21'b0, s2};
      res <= '0;
    end
    if (ctl.root && trial_sq <= val[15:0]) begin
      res <= trial;
    end
  end

  // Clamp anything at or above 256 squared
  assign mag = (val[26:16] != '0) ? 8'hFF : res;

endmodule

[rtl/sobel_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// 3x3 Sobel edge magnitude over a raster pixel stream, one lane per channel.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_stall       in_pix   (sem_in_t)
//  out      source     out_valid / out_stall     out_res  (sem_out_t)
//  cfg      sink       cfg_we                    cfg_index, cfg_data
//
//  One pixel at a time: accept, line store read and window shift, then for
//  an interior window gradient, square, gain and 8 root steps, then up to
//  two result beats. Reset clears counters, window and sequencer; line
//  stores need no clearing. A stalled result beat holds and blocks the next
//  pixel.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  sem_in_t     in_pix,
  output logic        out_valid,
  input  logic        out_stall,
  output sem_out_t    out_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam int PW = 8 * MAX_CHANNELS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHIFT  = 3'd1;
  localparam logic [2:0] ST_GRAD   = 3'd2;
  localparam logic [2:0] ST_SQ     = 3'd3;
  localparam logic [2:0] ST_SCALE  = 3'd4;
  localparam logic [2:0] ST_ROOT   = 3'd5;
  localparam logic [2:0] ST_EDGE   = 3'd6;
  localparam logic [2:0] ST_BORDER = 3'd7;

  logic [11:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  channel_count;
  logic [2:0]  sensitivity;

  logic [2:0]  state, state_next;
  logic [ROOT_BITS-1:0] root_cnt;
  logic [AW-1:0] col;
  logic [15:0]   row;
  logic [AW-1:0] c_reg;
  logic [15:0]   r_reg;
  logic          has_edge, has_border;
  logic [PW-1:0] pix_reg;
  logic [8:0][PW-1:0] win;

  logic [PW-1:0] up_rd, lo_rd;
  logic          in_acc;
  logic [WW-1:0] wext, weff, nc;
  logic [15:0]   heff, row_a, cur_r;
  logic [AW-1:0] cur_c;
  logic          wrap_c;
  logic [16:0]   nr;
  logic [2:0]    nch;
  logic [NUM_FIELDS_CH-1:0][7:0] in_ch;
  logic [PW-1:0] pix_next;
  sem_lane_ctl_t lane_ctl;
  logic [NUM_FIELDS_CH-1:0][7:0] mag;
  logic [31:0]   pix_wide;
  logic [NUM_FIELDS_CH-1:0][7:0] res_ch;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 12'd640;
      image_height  <= 16'd480;
      channel_count <= 3'd3;
      sensitivity   <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:    image_width   <= cfg_data[11:0];
        REG_HEIGHT:   image_height  <= cfg_data;
        REG_CHANNELS: channel_count <= cfg_data[2:0];
        REG_SENS:     sensitivity   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Effective geometry and position of the incoming pixel
  always_comb begin
    wext   = WW'(image_width);
    if (wext == '0) begin
      weff = WW'(1);
    end else if (wext > WW'(MAX_WIDTH)) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = wext;
    end
    heff   = (image_height == '0) ? 16'd1 : image_height;
    if (channel_count == '0) begin
      nch = 3'd1;
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      nch = 3'(MAX_CHANNELS);
    end else begin
      nch = channel_count;
    end
    wrap_c = (WW'(col) >= weff);
    row_a  = wrap_c ? row + 16'd1 : row;
    cur_r  = (row_a >= heff) ? 16'd0 : row_a;
    cur_c  = wrap_c ? '0 : col;
    nc     = WW'(cur_c) + WW'(1);
    nr     = {1'b0, cur_r} + 17'd1;
    in_ch  = {in_pix.pix_ch3, in_pix.pix_ch2, in_pix.pix_ch1, in_pix.pix_ch0};
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      pix_next[8*k +: 8] = (k < 32'(nch)) ? in_ch[k] : 8'd0;
    end
  end

  // Hold the pixel and its position; advance the raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_acc) begin
      if (nc >= weff) begin
        col <= '0;
        row <= (nr >= {1'b0, heff}) ? 16'd0 : nr[15:0];
      end else begin
        col <= nc[AW-1:0];
        row <= cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_reg      <= cur_c;
      r_reg      <= cur_r;
      pix_reg    <= pix_next;
      has_edge   <= (WW'(cur_c) >= WW'(2)) && (cur_r >= 16'd2);
      has_border <= (cur_c == '0) || (cur_r == '0) ||
                    (WW'(cur_c) == weff - WW'(1)) || (cur_r == heff - 16'd1);
    end
  end

  // Line stores: rows r-2 and r-1
  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (state == ST_SHIFT),
    .waddr (c_reg),
    .wdata (lo_rd),
    .raddr (cur_c),
    .rdata (up_rd)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_lower (
    .clk   (clk),
    .we    (state == ST_SHIFT),
    .waddr (c_reg),
    .wdata (pix_reg),
    .raddr (cur_c),
    .rdata (lo_rd)
  );

  // Shift the window one column
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (state == ST_SHIFT) begin
      for (int i = 0; i < 3; i++) begin
        win[3*i]     <= win[3*i+1];
        win[3*i + 1] <= win[3*i+2];
      end
      win[2] <= up_rd;
      win[5] <= lo_rd;
      win[8] <= pix_reg;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_acc) state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (has_edge) begin
          state_next = ST_GRAD;
        end else if (has_border) begin
          state_next = ST_BORDER;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_GRAD:   state_next = ST_SQ;
      ST_SQ:     state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ROOT;
      ST_ROOT:   if (root_cnt == '0) state_next = ST_EDGE;
      ST_EDGE:   if (!out_stall) state_next = has_border ? ST_BORDER : ST_IDLE;
      ST_BORDER: if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      root_cnt <= '1;
    end else begin
      state <= state_next;
      if (state == ST_SCALE) begin
        root_cnt <= '1;
      end else if (state == ST_ROOT) begin
        root_cnt <= root_cnt - 1'b1;
      end
    end
  end

  assign lane_ctl = '{grad:    (state == ST_GRAD),
                      square:  (state == ST_SQ),
                      scale:   (state == ST_SCALE),
                      root:    (state == ST_ROOT),
                      bit_idx: root_cnt};

  // One lane per channel
  for (genvar k = 0; k < NUM_FIELDS_CH; k++) begin : g_lane
    if (k < MAX_CHANNELS) begin : g_on
      logic [8:0][7:0] tap;
      for (genvar i = 0; i < 9; i++) begin : g_tap
        assign tap[i] = win[i][8*k +: 8];
      end
      sem_lane u_lane (
        .clk  (clk),
        .ctl  (lane_ctl),
        .sens (sensitivity),
        .tap  (tap),
        .mag  (mag[k])
      );
    end else begin : g_off
      assign mag[k] = 8'd0;
    end
  end

  // Merge lanes into the result beat
  always_comb begin
    pix_wide = 32'(pix_reg);
    for (int k = 0; k < NUM_FIELDS_CH; k++) begin
      if (state == ST_EDGE) begin
        res_ch[k] = (k < 32'(nch)) ? mag[k] : 8'd0;
      end else begin
        res_ch[k] = pix_wide[8*k +: 8];
      end
    end
  end

  assign out_valid        = (state == ST_EDGE) || (state == ST_BORDER);
  assign out_res.out_col  = (state == ST_EDGE) ? 11'(c_reg - 1'b1) : 11'(c_reg);
  assign out_res.out_row  = (state == ST_EDGE) ? r_reg - 16'd1 : r_reg;
  assign out_res.res_ch0  = res_ch[0];
  assign out_res.res_ch1  = res_ch[1];
  assign out_res.res_ch2  = res_ch[2];
  assign out_res.res_ch3  = res_ch[3];
  assign out_res.run_last = (state == ST_BORDER) || !has_border;

  // Checks
  a_accept_shift: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_SHIFT) else $error("accepted pixel did not shift");
  a_edge_flag: assert property (@(posedge clk) disable iff (rst)
    state == ST_EDGE |-> has_edge) else $error("edge beat without interior window");
  a_root_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT && root_cnt == '0) |=> state == ST_EDGE)
    else $error("root loop did not finish into edge beat");
  a_border_flag: assert property (@(posedge clk) disable iff (rst)
    state == ST_BORDER |-> has_border) else $error("border beat without border pixel");

endmodule
